>>> rtl/per_track_sliding_mode_vote_assert.svh
// Assertion macros for the per-track sliding mode vote block.
// Used by the checker module. Depends on nothing else.
`ifndef PER_TRACK_SLIDING_MODE_VOTE_ASSERT_SVH
`define PER_TRACK_SLIDING_MODE_VOTE_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define PTSMV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PTSMV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ptsmv_pkg.sv
// Shared types and constants of the per-track sliding mode vote block.
// Depends on nothing; the top level and the checker import it.
package ptsmv_pkg;

   // Fixed field widths of the request and response beats.
   localparam int unsigned OP_FIELD_BITS    = 1;
   localparam int unsigned SLOT_FIELD_BITS  = 4;
   localparam int unsigned LABEL_FIELD_BITS = 8;
   localparam int unsigned VOTES_FIELD_BITS = 4;

   // Operation codes.
   localparam logic [OP_FIELD_BITS-1:0] OP_VOTE  = 1'b0;
   localparam logic [OP_FIELD_BITS-1:0] OP_CLEAR = 1'b1;

   typedef struct packed {
      logic [OP_FIELD_BITS-1:0]    operation;
      logic [SLOT_FIELD_BITS-1:0]  track_slot;
      logic [LABEL_FIELD_BITS-1:0] label_code;
   } req_type;

   typedef struct packed {
      logic [LABEL_FIELD_BITS-1:0] winner_label;
      logic [VOTES_FIELD_BITS-1:0] winner_votes;
   } rsp_type;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_RESULT
   } vote_state_type;

endpackage

>>> rtl/ptsmv_row_mem.sv
// Window row memory: one row per track slot, one write and one read port.
// Read data is registered; rows never written read as the reset row.
// Depends on nothing but its parameters.
module ptsmv_row_mem #(
   parameter int unsigned ROW_BITS  = 72,
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned ADDR_BITS = 4,
   parameter logic [ROW_BITS-1:0] RESET_ROW = '0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [ROW_BITS-1:0]  rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [ROW_BITS-1:0]  wr_data
);

   logic [ROW_BITS-1:0] row_ram [DEPTH];
   logic [DEPTH-1:0]    row_written_ff;
   logic [ROW_BITS-1:0] rd_data_ff;
   logic                rd_written_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= row_ram[rd_addr];
      end
   end

   // One written flag per row stands in for clearing the array at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_written_ff <= '0;
         rd_written_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= row_written_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : RESET_ROW;

endmodule

>>> rtl/ptsmv_mode_scan.sv
// Mode scanner: walks the window positions one per cycle and keeps the label
// with the highest count, smallest code on a tie. Depends on no package.
module ptsmv_mode_scan #(
   parameter int unsigned WINDOW_LENGTH = 8,
   parameter int unsigned LABEL_BITS    = 8,
   parameter int unsigned POS_BITS      = 3,
   parameter int unsigned CNT_BITS      = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [WINDOW_LENGTH-1:0][LABEL_BITS-1:0] labels,
   input  logic [CNT_BITS-1:0]                   fill,
   input  logic [POS_BITS-1:0]                   oldest,
   output logic                                  done,
   output logic [LABEL_BITS-1:0]                 best_label,
   output logic [CNT_BITS-1:0]                   best_count
);

   logic [WINDOW_LENGTH-1:0][LABEL_BITS-1:0] labels_ff;
   logic [WINDOW_LENGTH-1:0]                 stored_ff;
   logic [WINDOW_LENGTH-1:0]                 stored_in;
   logic [POS_BITS-1:0]                      idx_ff;
   logic                                     busy_ff;
   logic                                     done_ff;
   logic [LABEL_BITS-1:0]                    best_label_ff;
   logic [CNT_BITS-1:0]                      best_count_ff;
   logic [LABEL_BITS-1:0]                    cand;
   logic [WINDOW_LENGTH-1:0]                 match;
   logic [CNT_BITS-1:0]                      cand_count;
   logic                                     better;
   logic                                     last_pos;

   // A position holds an entry when its distance from the oldest one is below the fill.
   always_comb begin
      int age;
      age = 0;
      for (int p = 0; p < int'(WINDOW_LENGTH); p++) begin
         if (p >= int'(oldest)) begin
            age = p - int'(oldest);
         end else begin
            age = p + int'(WINDOW_LENGTH) - int'(oldest);
         end
         stored_in[p] = (age < int'(fill));
      end
   end

   // Count the entries equal to the candidate at the current position.
   always_comb begin
      cand = labels_ff[idx_ff];
      for (int j = 0; j < int'(WINDOW_LENGTH); j++) begin
         match[j] = stored_ff[j] && (labels_ff[j] == cand);
      end
      cand_count = CNT_BITS'($countones(match));
      better = stored_ff[idx_ff] &&
               ((cand_count > best_count_ff) ||
                ((cand_count == best_count_ff) && (cand < best_label_ff)));
      last_pos = (idx_ff == POS_BITS'(WINDOW_LENGTH - 1));
   end

   // Window snapshot, taken when a scan starts.
   always_ff @(posedge clock) begin
      if (start) begin
         labels_ff <= labels;
         stored_ff <= stored_in;
      end
   end

   // Scan control and best-so-far registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         done_ff       <= 1'b0;
         idx_ff        <= '0;
         best_label_ff <= '0;
         best_count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff       <= 1'b1;
            idx_ff        <= '0;
            best_label_ff <= '0;
            best_count_ff <= '0;
         end else if (busy_ff) begin
            if (better) begin
               best_label_ff <= cand;
               best_count_ff <= cand_count;
            end
            if (last_pos) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   assign done       = done_ff;
   assign best_label = best_label_ff;
   assign best_count = best_count_ff;

endmodule

>>> rtl/per_track_sliding_mode_vote.sv
// Per-track sliding-window mode vote: a vote beat appends its label to the
// slot's window and returns the most frequent stored label with its count
// (smallest code on a tie); a clear beat empties the window and returns no
// beat. A vote reads the row, updates and writes back the row, and then
// scans the window positions one by one for the mode before the response
// beat. A clear writes the row at acceptance; a beat for an out-of-range
// slot is dropped with no response. The window state of all slots lives
// in one row memory; rows read as a full window of zero labels after reset,
// with no clearing pass. A new request is taken while a response beat still
// waits. Depends on ptsmv_pkg, ptsmv_row_mem and ptsmv_mode_scan.
module per_track_sliding_mode_vote #(
   parameter int unsigned WINDOW_LENGTH = 8,
   parameter int unsigned TRACK_SLOTS   = 16,
   parameter int unsigned LABEL_BITS    = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ptsmv_pkg::req_type req_beat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ptsmv_pkg::rsp_type rsp_beat
);

   import ptsmv_pkg::*;

   localparam int unsigned POS_BITS  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int unsigned CNT_BITS  = $clog2(WINDOW_LENGTH + 1);
   localparam int unsigned SLOT_BITS = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
   localparam int unsigned VEC_BITS  = WINDOW_LENGTH * LABEL_BITS;
   localparam int unsigned ROW_BITS  = VEC_BITS + CNT_BITS + POS_BITS;
   localparam logic [ROW_BITS-1:0] RESET_ROW =
      {POS_BITS'(0), CNT_BITS'(WINDOW_LENGTH), VEC_BITS'(0)};
   localparam logic [ROW_BITS-1:0] CLEAR_ROW =
      {POS_BITS'(0), CNT_BITS'(0), VEC_BITS'(0)};

   vote_state_type state_ff, state_in;

   logic [SLOT_BITS-1:0]  slot_ff;
   logic [LABEL_BITS-1:0] label_ff;
   rsp_type               rsp_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_accept;
   logic                  slot_in_range;
   logic [SLOT_BITS-1:0]  req_slot;
   logic                  mem_rd_en;
   logic                  mem_wr_en;
   logic [SLOT_BITS-1:0]  mem_wr_addr;
   logic [ROW_BITS-1:0]   mem_wr_data;
   logic [ROW_BITS-1:0]   mem_rd_data;

   logic [WINDOW_LENGTH-1:0][LABEL_BITS-1:0] rd_labels, new_labels;
   logic [CNT_BITS-1:0]   rd_fill, new_fill;
   logic [POS_BITS-1:0]   rd_oldest, new_oldest, wr_pos;
   logic [CNT_BITS:0]     tail_sum;

   logic                  scan_start;
   logic                  scan_done;
   logic [LABEL_BITS-1:0] best_label;
   logic [CNT_BITS-1:0]   best_count;
   logic                  rsp_load;

   // Request decode.
   assign req_ready     = (state_ff == ST_IDLE);
   assign req_accept    = req_valid && req_ready;
   assign slot_in_range = (int'(req_beat.track_slot) < int'(TRACK_SLOTS));
   assign req_slot      = SLOT_BITS'(req_beat.track_slot);

   // Row update: unpack, append the label at the tail, repack.
   always_comb begin
      rd_labels  = mem_rd_data[VEC_BITS-1:0];
      rd_fill    = mem_rd_data[VEC_BITS +: CNT_BITS];
      rd_oldest  = mem_rd_data[VEC_BITS + CNT_BITS +: POS_BITS];
      tail_sum   = (CNT_BITS + 1)'(rd_oldest) + (CNT_BITS + 1)'(rd_fill);
      if (rd_fill >= CNT_BITS'(WINDOW_LENGTH)) begin
         wr_pos   = rd_oldest;
         new_fill = CNT_BITS'(WINDOW_LENGTH);
         if (rd_oldest == POS_BITS'(WINDOW_LENGTH - 1)) begin
            new_oldest = '0;
         end else begin
            new_oldest = rd_oldest + 1'b1;
         end
      end else begin
         if (tail_sum >= (CNT_BITS + 1)'(WINDOW_LENGTH)) begin
            wr_pos = POS_BITS'(tail_sum - (CNT_BITS + 1)'(WINDOW_LENGTH));
         end else begin
            wr_pos = POS_BITS'(tail_sum);
         end
         new_fill   = rd_fill + 1'b1;
         new_oldest = rd_oldest;
      end
      new_labels         = rd_labels;
      new_labels[wr_pos] = label_ff;
   end

   // Memory port control: reads at vote acceptance, writes on clear or update.
   always_comb begin
      mem_rd_en   = req_accept && slot_in_range && (req_beat.operation == OP_VOTE);
      mem_wr_en   = 1'b0;
      mem_wr_addr = slot_ff;
      mem_wr_data = {new_oldest, new_fill, new_labels};
      if (state_ff == ST_MODIFY) begin
         mem_wr_en = 1'b1;
      end else if (req_accept && slot_in_range && (req_beat.operation == OP_CLEAR)) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = req_slot;
         mem_wr_data = CLEAR_ROW;
      end
   end

   // Next state and response load.
   always_comb begin
      state_in   = state_ff;
      scan_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (mem_rd_en) begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            scan_start = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         slot_ff  <= req_slot;
         label_ff <= LABEL_BITS'(req_beat.label_code);
      end
      if (rsp_load) begin
         rsp_data_ff.winner_label <= LABEL_FIELD_BITS'(best_label);
         rsp_data_ff.winner_votes <= VOTES_FIELD_BITS'(best_count);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_data_ff;

   ptsmv_row_mem #(
      .ROW_BITS  (ROW_BITS),
      .DEPTH     (TRACK_SLOTS),
      .ADDR_BITS (SLOT_BITS),
      .RESET_ROW (RESET_ROW)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (req_slot),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   ptsmv_mode_scan #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .LABEL_BITS    (LABEL_BITS),
      .POS_BITS      (POS_BITS),
      .CNT_BITS      (CNT_BITS)
   ) u_mode_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .labels     (new_labels),
      .fill       (new_fill),
      .oldest     (new_oldest),
      .done       (scan_done),
      .best_label (best_label),
      .best_count (best_count)
   );

endmodule

>>> rtl/ptsmv_checker.sv
// Port-level checker for the per-track sliding mode vote block, with its bind.
// Depends on ptsmv_pkg and per_track_sliding_mode_vote_assert.svh.
`include "per_track_sliding_mode_vote_assert.svh"

module ptsmv_checker #(
   parameter int unsigned WINDOW_LENGTH = 8,
   parameter int unsigned TRACK_SLOTS   = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input ptsmv_pkg::req_type req_beat,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ptsmv_pkg::rsp_type rsp_beat
);

   import ptsmv_pkg::*;

   logic vote_beat;
   logic clear_beat;

   assign vote_beat  = req_valid && req_ready && (req_beat.operation == OP_VOTE) &&
                       (int'(req_beat.track_slot) < int'(TRACK_SLOTS));
   assign clear_beat = req_valid && req_ready && (req_beat.operation == OP_CLEAR);

   // A stalled response beat holds its payload.
   `PTSMV_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_beat)), "response beat dropped or changed while stalled")

   // No response beat is left over from before a reset.
   `PTSMV_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "response valid after reset")

   // A window never reports zero votes, nor more than WINDOW_LENGTH, while the count fits its field.
   `PTSMV_ASSERT(a_votes_nonzero, clock, reset, rsp_valid |-> ((WINDOW_LENGTH >= 16) || ((rsp_beat.winner_votes != 4'd0) && (int'(rsp_beat.winner_votes) <= int'(WINDOW_LENGTH)))), "winner votes out of range")

   // A clear beat produces no response beat.
   `PTSMV_ASSERT(a_clear_silent, clock, reset, (clear_beat && !rsp_valid) |=> !rsp_valid, "clear beat produced a response")

   // A vote keeps the request side closed while it is being worked on.
   `PTSMV_ASSERT(a_vote_busy, clock, reset, vote_beat |=> !req_ready, "request taken during a vote")

endmodule

bind per_track_sliding_mode_vote ptsmv_checker #(
   .WINDOW_LENGTH (WINDOW_LENGTH),
   .TRACK_SLOTS   (TRACK_SLOTS)
) u_ptsmv_checker (.*);
